// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define BEI_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define BEI_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/bei_pkg.sv -----
// ----------------------------------------------------------------------------
// bei_pkg
// Types, codes and the cosine weight function of the envelope interpolator.
// ----------------------------------------------------------------------------
package bei_pkg;

    localparam int DEF_MAX_POINTS     = 64;
    localparam int DEF_COS_TABLE_SIZE = 256;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_SET    = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_EVAL   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [1:0] MODE_STEP   = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;
    localparam logic [1:0] MODE_COSINE = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ADD_RD,
        OP_SHIFT_UP,
        OP_INSERT,
        OP_REM_RD,
        OP_SHIFT_DN,
        OP_DEC,
        OP_SET,
        OP_CLR,
        OP_EV_RD,
        OP_TAKE_A,
        OP_TAKE_B,
        OP_SRCH_INIT,
        OP_SRCH_RD,
        OP_SRCH_UPD,
        OP_PAIR_RD,
        OP_SETUP,
        OP_DIV_STEP,
        OP_WIDX,
        OP_WEIGHT,
        OP_MUL,
        OP_ROUND
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_ctrl_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       fail;
        logic       i_zero;
        logic       a_gt;
        logic       rem_last;
        logic       ends_a;
        logic       ends_b;
        logic       adj;
        logic       step_mode;
        logic       div_last;
    } dp_stat_t;

    // sin^2 weight in Q1.16 from a Q30 angle; elaboration only
    function automatic logic [16:0] cos_weight(input logic [63:0] y);
        logic [63:0] y2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] s;
        logic [63:0] sq;
        y2   = (y * y) >> 30;
        term = y;
        pos  = y;
        neg  = 64'd0;
        for (int k = 1; k <= 12; k++) begin
            term = (term * y2) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                neg = neg + term;
            end
            else begin
                pos = pos + term;
            end
        end
        s = (pos > neg) ? pos - neg : 64'd0;
        if (s > ONE_Q30) begin
            s = ONE_Q30;
        end
        sq = (s * s + (64'd1 << 43)) >> 44;
        return sq[16:0];
    endfunction

endpackage

// ----- rtl/core/bei_cos_rom.sv -----
// ----------------------------------------------------------------------------
// bei_cos_rom
// Raised-cosine weight table, built at elaboration.
// ----------------------------------------------------------------------------
module bei_cos_rom
    import bei_pkg::*;
#(
    parameter int COS_TABLE_SIZE = DEF_COS_TABLE_SIZE,
    localparam int SW = $clog2(COS_TABLE_SIZE)
)
(
    input  logic [SW-1:0] index,
    output logic [16:0]   weight
);

    logic [16:0] rom [COS_TABLE_SIZE];

    for (genvar g = 0; g < COS_TABLE_SIZE; g++) begin : g_rom
        localparam logic [63:0] ANGLE =
            (PI_HALF_Q30 * 64'(g) + 64'(COS_TABLE_SIZE / 2)) / 64'(COS_TABLE_SIZE);
        assign rom[g] = cos_weight(ANGLE);
    end

    assign weight = rom[index];

endmodule

// ----- rtl/core/bei_datapath.sv -----
// ----------------------------------------------------------------------------
// bei_datapath
// Breakpoint memories, search indices, serial divider and weighting multiply.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bei_datapath
    import bei_pkg::*;
#(
    parameter int MAX_POINTS     = DEF_MAX_POINTS,
    parameter int COS_TABLE_SIZE = DEF_COS_TABLE_SIZE,
    localparam int AW = $clog2(MAX_POINTS),
    localparam int CW = $clog2(MAX_POINTS + 1),
    localparam int SW = $clog2(COS_TABLE_SIZE)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_ctrl_t           ctrl,
    output dp_stat_t           stat,
    input  logic [2:0]         cmd,
    input  logic [31:0]        position,
    input  logic signed [31:0] point_value,
    input  logic [5:0]         point_index,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_data,
    output logic signed [31:0] result_value,
    output logic [1:0]         status,
    output logic [6:0]         stored_count
);

    logic [31:0] pos_mem [MAX_POINTS];
    logic [31:0] val_mem [MAX_POINTS];

    logic [CW-1:0]      count_reg;
    logic [1:0]         mode_reg;
    logic [2:0]         cmd_reg;
    logic [31:0]        pos_reg;
    logic [31:0]        val_reg;
    logic [AW-1:0]      i_reg;
    logic [AW-1:0]      lo_reg;
    logic [AW-1:0]      hi_reg;
    logic [AW-1:0]      mid_reg;
    logic [31:0]        rda_pos_reg;
    logic [31:0]        rda_val_reg;
    logic [31:0]        rdb_pos_reg;
    logic [31:0]        rdb_val_reg;
    logic [31:0]        span_reg;
    logic [31:0]        rem_reg;
    logic [15:0]        q_reg;
    logic [3:0]         dcnt_reg;
    logic signed [32:0] d_reg;
    logic [31:0]        v1_reg;
    logic [SW-1:0]      widx_reg;
    logic [16:0]        w_reg;
    logic signed [50:0] prod_reg;
    logic signed [31:0] result_reg;
    logic [1:0]         status_reg;

    logic               full;
    logic               idx_oob;
    logic [AW-1:0]      idx_cut;
    logic [AW:0]        mid_sum;
    logic [AW-1:0]      mid;
    logic [AW-1:0]      last_idx;
    logic               rd_en;
    logic [AW-1:0]      rd_addr_a;
    logic [AW-1:0]      rd_addr_b;
    logic               pos_we;
    logic               val_we;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_pos;
    logic [31:0]        wr_val;
    logic [32:0]        rem_sh;
    logic               rem_ge;
    logic [16+SW:0]     scaled;
    logic [16:0]        rom_w;
    logic signed [50:0] rnd;
    logic signed [50:0] rnd_sh;
    logic [1:0]         load_status;

    assign full     = count_reg >= CW'(MAX_POINTS);
    assign idx_oob  = point_index >= count_reg;
    assign idx_cut  = AW'(point_index);
    assign mid_sum  = (AW + 1)'(lo_reg) + (AW + 1)'(hi_reg);
    assign mid      = mid_sum[AW:1];
    assign last_idx = AW'(count_reg - CW'(1));
    assign rem_sh   = {rem_reg, 1'b0};
    assign rem_ge   = rem_sh >= {1'b0, span_reg};
    assign scaled   = (17 + SW)'(q_reg) * (17 + SW)'(COS_TABLE_SIZE);
    assign rnd      = prod_reg + 51'sd32768;
    assign rnd_sh   = rnd >>> 16;

    bei_cos_rom #(
        .COS_TABLE_SIZE(COS_TABLE_SIZE)
    ) u_rom (
        .index (widx_reg),
        .weight(rom_w)
    );

    always_comb
    begin
        unique case (cmd)
            CMD_ADD:    load_status = full ? ST_FULL : ST_OK;
            CMD_REMOVE: load_status = idx_oob ? ST_RANGE : ST_OK;
            CMD_SET:    load_status = idx_oob ? ST_RANGE : ST_OK;
            CMD_EVAL:   load_status = (count_reg == '0) ? ST_EMPTY : ST_OK;
            default:    load_status = ST_OK;
        endcase
    end

    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr_a = i_reg - AW'(1);
        rd_addr_b = hi_reg;
        pos_we    = 1'b0;
        val_we    = 1'b0;
        wr_addr   = i_reg;
        wr_pos    = rda_pos_reg;
        wr_val    = rda_val_reg;
        unique case (ctrl.op)
            OP_ADD_RD:
            begin
                rd_en = 1'b1;
            end
            OP_REM_RD:
            begin
                rd_en     = 1'b1;
                rd_addr_a = i_reg + AW'(1);
            end
            OP_EV_RD:
            begin
                rd_en     = 1'b1;
                rd_addr_a = '0;
                rd_addr_b = last_idx;
            end
            OP_SRCH_RD:
            begin
                rd_en     = 1'b1;
                rd_addr_a = mid;
            end
            OP_PAIR_RD:
            begin
                rd_en     = 1'b1;
                rd_addr_a = lo_reg;
            end
            OP_SHIFT_UP, OP_SHIFT_DN:
            begin
                pos_we = 1'b1;
                val_we = 1'b1;
            end
            OP_INSERT:
            begin
                pos_we = 1'b1;
                val_we = 1'b1;
                wr_pos = pos_reg;
                wr_val = val_reg;
            end
            OP_SET:
            begin
                val_we = 1'b1;
                wr_val = val_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[wr_addr] <= wr_pos;
        end
        if (val_we)
        begin
            val_mem[wr_addr] <= wr_val;
        end
        if (rd_en)
        begin
            rda_pos_reg <= pos_mem[rd_addr_a];
            rda_val_reg <= val_mem[rd_addr_a];
            rdb_pos_reg <= pos_mem[rd_addr_b];
            rdb_val_reg <= val_mem[rd_addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            mode_reg  <= MODE_LINEAR;
        end
        else
        begin
            if (cfg_write)
            begin
                mode_reg <= cfg_data;
            end
            unique case (ctrl.op)
                OP_INSERT: count_reg <= count_reg + CW'(1);
                OP_DEC:    count_reg <= count_reg - CW'(1);
                OP_CLR:    count_reg <= '0;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            OP_LOAD:
            begin
                cmd_reg    <= cmd;
                pos_reg    <= position;
                val_reg    <= point_value;
                i_reg      <= (cmd == CMD_ADD) ? AW'(count_reg) : idx_cut;
                status_reg <= load_status;
                result_reg <= '0;
            end
            OP_SHIFT_UP:
            begin
                i_reg <= i_reg - AW'(1);
            end
            OP_SHIFT_DN:
            begin
                i_reg <= i_reg + AW'(1);
            end
            OP_TAKE_A:
            begin
                result_reg <= rda_val_reg;
            end
            OP_TAKE_B:
            begin
                result_reg <= rdb_val_reg;
            end
            OP_SRCH_INIT:
            begin
                lo_reg <= '0;
                hi_reg <= last_idx;
            end
            OP_SRCH_RD:
            begin
                mid_reg <= mid;
            end
            OP_SRCH_UPD:
            begin
                if (rda_pos_reg <= pos_reg)
                begin
                    lo_reg <= mid_reg;
                end
                else
                begin
                    hi_reg <= mid_reg;
                end
            end
            OP_SETUP:
            begin
                span_reg <= rdb_pos_reg - rda_pos_reg;
                rem_reg  <= pos_reg - rda_pos_reg;
                q_reg    <= '0;
                dcnt_reg <= '0;
                v1_reg   <= rda_val_reg;
                d_reg    <= 33'(signed'(rdb_val_reg)) - 33'(signed'(rda_val_reg));
            end
            OP_DIV_STEP:
            begin
                // restoring step: one quotient bit per cycle
                rem_reg  <= rem_ge ? 32'(rem_sh - {1'b0, span_reg}) : rem_sh[31:0];
                q_reg    <= {q_reg[14:0], rem_ge};
                dcnt_reg <= dcnt_reg + 4'd1;
            end
            OP_WIDX:
            begin
                widx_reg <= scaled[16 +: SW];
            end
            OP_WEIGHT:
            begin
                w_reg <= (mode_reg == MODE_LINEAR) ? {1'b0, q_reg} : rom_w;
            end
            OP_MUL:
            begin
                prod_reg <= 51'(signed'({1'b0, w_reg}) * d_reg);
            end
            OP_ROUND:
            begin
                result_reg <= signed'(v1_reg + rnd_sh[31:0]);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stat.cmd       = cmd_reg;
        stat.fail      = status_reg != ST_OK;
        stat.i_zero    = i_reg == '0;
        stat.a_gt      = rda_pos_reg > pos_reg;
        stat.rem_last  = (CW'(i_reg) + CW'(1)) >= count_reg;
        stat.ends_a    = (count_reg == CW'(1)) || (pos_reg <= rda_pos_reg);
        stat.ends_b    = pos_reg >= rdb_pos_reg;
        stat.adj       = (hi_reg - lo_reg) == AW'(1);
        stat.step_mode = (mode_reg != MODE_LINEAR) && (mode_reg != MODE_COSINE);
        stat.div_last  = dcnt_reg == 4'd15;
    end

    assign result_value = result_reg;
    assign status       = status_reg;
    assign stored_count = 7'(count_reg);

    `BEI_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_reg <= CW'(MAX_POINTS))
    `BEI_ASSERT_IMP(a_insert_room, clk, rst_n, ctrl.op == OP_INSERT, !full)
    `BEI_ASSERT_IMP(a_search_order, clk, rst_n, ctrl.op == OP_SRCH_RD, lo_reg < hi_reg)

endmodule

// ----- rtl/core/bei_ctrl.sv -----
// ----------------------------------------------------------------------------
// bei_ctrl
// Sequencer: steps the datapath through edit, search and interpolation.
// ----------------------------------------------------------------------------
module bei_ctrl
    import bei_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl,
    output logic     busy,
    output logic     done
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADD_CHK,
        S_ADD_CMP,
        S_REM_CHK,
        S_REM_WR,
        S_EV_ENDS,
        S_SRCH_CHK,
        S_SRCH_UPD,
        S_PAIR,
        S_DIV,
        S_WIDX,
        S_WEIGHT,
        S_MUL,
        S_ROUND,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        ctrl.op    = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.op    = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_FINISH;
                if (!stat.fail)
                begin
                    unique case (stat.cmd)
                        CMD_ADD:    state_next = S_ADD_CHK;
                        CMD_REMOVE: state_next = S_REM_CHK;
                        CMD_SET:    ctrl.op = OP_SET;
                        CMD_CLEAR:  ctrl.op = OP_CLR;
                        CMD_EVAL:
                        begin
                            ctrl.op    = OP_EV_RD;
                            state_next = S_EV_ENDS;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ADD_CHK:
            begin
                if (stat.i_zero)
                begin
                    ctrl.op    = OP_INSERT;
                    state_next = S_FINISH;
                end
                else
                begin
                    ctrl.op    = OP_ADD_RD;
                    state_next = S_ADD_CMP;
                end
            end
            S_ADD_CMP:
            begin
                // move entries up while they lie past the new position
                if (stat.a_gt)
                begin
                    ctrl.op    = OP_SHIFT_UP;
                    state_next = S_ADD_CHK;
                end
                else
                begin
                    ctrl.op    = OP_INSERT;
                    state_next = S_FINISH;
                end
            end
            S_REM_CHK:
            begin
                if (stat.rem_last)
                begin
                    ctrl.op    = OP_DEC;
                    state_next = S_FINISH;
                end
                else
                begin
                    ctrl.op    = OP_REM_RD;
                    state_next = S_REM_WR;
                end
            end
            S_REM_WR:
            begin
                ctrl.op    = OP_SHIFT_DN;
                state_next = S_REM_CHK;
            end
            S_EV_ENDS:
            begin
                priority if (stat.ends_a)
                begin
                    ctrl.op    = OP_TAKE_A;
                    state_next = S_FINISH;
                end
                else if (stat.ends_b)
                begin
                    ctrl.op    = OP_TAKE_B;
                    state_next = S_FINISH;
                end
                else
                begin
                    ctrl.op    = OP_SRCH_INIT;
                    state_next = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK:
            begin
                if (stat.adj)
                begin
                    ctrl.op    = OP_PAIR_RD;
                    state_next = S_PAIR;
                end
                else
                begin
                    ctrl.op    = OP_SRCH_RD;
                    state_next = S_SRCH_UPD;
                end
            end
            S_SRCH_UPD:
            begin
                ctrl.op    = OP_SRCH_UPD;
                state_next = S_SRCH_CHK;
            end
            S_PAIR:
            begin
                if (stat.step_mode)
                begin
                    ctrl.op    = OP_TAKE_A;
                    state_next = S_FINISH;
                end
                else
                begin
                    ctrl.op    = OP_SETUP;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                ctrl.op = OP_DIV_STEP;
                if (stat.div_last)
                begin
                    state_next = S_WIDX;
                end
            end
            S_WIDX:
            begin
                ctrl.op    = OP_WIDX;
                state_next = S_WEIGHT;
            end
            S_WEIGHT:
            begin
                ctrl.op    = OP_WEIGHT;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                ctrl.op    = OP_MUL;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                ctrl.op    = OP_ROUND;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= state_next != S_IDLE;
            done_reg  <= state_next == S_FINISH;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ----- rtl/core/breakpoint_envelope_interpolator.sv -----
// ----------------------------------------------------------------------------
// breakpoint_envelope_interpolator
// Sorted breakpoint table with step, linear and raised-cosine evaluation.
//
//   channel  | handshake           | payload
//   request  | start, busy         | cmd, position, point_value, point_index
//   result   | done (1-cycle)      | result_value, status, stored_count
//   config   | cfg_write           | cfg_data (interp_mode)
//
// One request at a time; busy is high from acceptance until done.
// Add and remove move one entry at a time. Evaluate runs a binary search,
// then the serial divider, then weight, multiply and round. Reset clears
// the count, mode linear.
// The result cannot be held off: it is valid while done is high and holds until the next request.
// ----------------------------------------------------------------------------
module breakpoint_envelope_interpolator
    import bei_pkg::*;
#(
    parameter int MAX_POINTS     = DEF_MAX_POINTS,
    parameter int COS_TABLE_SIZE = DEF_COS_TABLE_SIZE
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         cmd,
    input  logic [31:0]        position,
    input  logic signed [31:0] point_value,
    input  logic [5:0]         point_index,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_data,
    output logic               done,
    output logic signed [31:0] result_value,
    output logic [1:0]         status,
    output logic [6:0]         stored_count
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    bei_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .stat (stat),
        .ctrl (ctrl),
        .busy (busy),
        .done (done)
    );

    bei_datapath #(
        .MAX_POINTS    (MAX_POINTS),
        .COS_TABLE_SIZE(COS_TABLE_SIZE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .stat        (stat),
        .cmd         (cmd),
        .position    (position),
        .point_value (point_value),
        .point_index (point_index),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .result_value(result_value),
        .status      (status),
        .stored_count(stored_count)
    );

endmodule

// ----- verif/tb_breakpoint_envelope_interpolator.sv -----
// ----------------------------------------------------------------------------
// tb_breakpoint_envelope_interpolator
// Self-checking bench for the sorted breakpoint envelope: a queued request
// driver with random gaps, a result monitor and a predictor of the table and
// of step, linear and raised-cosine evaluation, run under every mode setting.
// ----------------------------------------------------------------------------
module tb_breakpoint_envelope_interpolator;
    import bei_pkg::*;

    localparam int NPTS      = 64;
    localparam int ROM_SIZE  = 256;
    localparam int LIMIT     = 1000000;
    localparam int PHASE_LEN = 240;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] pos;
        logic [31:0] val;
        logic [5:0]  idx;
    } env_req_t;

    typedef struct {
        logic [31:0] val;
        logic [1:0]  st;
        logic [6:0]  cnt;
    } env_res_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         cmd;
    logic [31:0]        position;
    logic signed [31:0] point_value;
    logic [5:0]         point_index;
    logic               cfg_write;
    logic [1:0]         cfg_data;
    logic               done;
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic [6:0]         stored_count;

    env_req_t    pending_reqs[$];
    env_res_t    expected_results[$];
    logic [31:0] tbl_pos[NPTS];
    logic [31:0] tbl_val[NPTS];
    int          pts;
    logic [1:0]  mode_q;
    longint unsigned weight_rom[ROM_SIZE];
    int          errors;
    int          accepted;
    int          n_eval;
    int          n_full;
    int          n_range;
    int          n_empty;
    int          cycles;
    int          gen_count;

    breakpoint_envelope_interpolator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .position     (position),
        .point_value  (point_value),
        .point_index  (point_index),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .done         (done),
        .result_value (result_value),
        .status       (status),
        .stored_count (stored_count)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // Taylor-series sin^2 weights, Q1.16
    task automatic fill_weights();
        longint unsigned y, y2, term, p, n, s;
        for (int i = 0; i < ROM_SIZE; i++)
        begin
            y = (64'd1686629713 * i + ROM_SIZE / 2) / ROM_SIZE;
            y2 = (y * y) >> 30;
            term = y;
            p = y;
            n = 0;
            for (int k = 1; k <= 12; k++)
            begin
                term = (term * y2) >> 30;
                term = term / ((2 * k) * (2 * k + 1));
                if (k % 2 == 1) n += term;
                else p += term;
            end
            s = (p > n) ? p - n : 0;
            if (s > 64'd1073741824) s = 64'd1073741824;
            weight_rom[i] = (s * s + (64'd1 << 43)) >> 44;
        end
    endtask

    function automatic longint envelope_at(input logic [31:0] at);
        int k;
        longint v1, d, w, x;
        longint unsigned t, span;
        int widx;
        if (pts == 1 || at <= tbl_pos[0]) return longint'($signed(tbl_val[0]));
        if (at >= tbl_pos[pts-1]) return longint'($signed(tbl_val[pts-1]));
        k = 1;
        while (k < pts - 1 && tbl_pos[k] <= at) k++;
        v1 = longint'($signed(tbl_val[k-1]));
        if (mode_q != MODE_LINEAR && mode_q != MODE_COSINE) return v1;
        d = longint'($signed(tbl_val[k])) - v1;
        span = 64'(tbl_pos[k] - tbl_pos[k-1]);
        t = (64'(at - tbl_pos[k-1]) << 16) / span;
        if (mode_q == MODE_LINEAR) w = longint'(t);
        else
        begin
            widx = int'((t * ROM_SIZE) >> 16);
            if (widx >= ROM_SIZE) widx = ROM_SIZE - 1;
            w = longint'(weight_rom[widx]);
        end
        x = w * d + 32768;
        return v1 + (x >>> 16);
    endfunction

    function automatic env_res_t apply_request(input env_req_t r);
        env_res_t res;
        int at;
        res.val = '0;
        res.st  = ST_OK;
        case (r.cmd)
            CMD_ADD:
            begin
                if (pts >= NPTS) res.st = ST_FULL;
                else
                begin
                    at = 0;
                    while (at < pts && tbl_pos[at] <= r.pos) at++;
                    for (int i = pts; i > at; i--)
                    begin
                        tbl_pos[i] = tbl_pos[i-1];
                        tbl_val[i] = tbl_val[i-1];
                    end
                    tbl_pos[at] = r.pos;
                    tbl_val[at] = r.val;
                    pts++;
                end
            end
            CMD_REMOVE:
            begin
                if (r.idx >= pts) res.st = ST_RANGE;
                else
                begin
                    for (int i = r.idx; i + 1 < pts; i++)
                    begin
                        tbl_pos[i] = tbl_pos[i+1];
                        tbl_val[i] = tbl_val[i+1];
                    end
                    pts--;
                end
            end
            CMD_SET:
            begin
                if (r.idx >= pts) res.st = ST_RANGE;
                else tbl_val[r.idx] = r.val;
            end
            CMD_CLEAR: pts = 0;
            CMD_EVAL:
            begin
                n_eval++;
                if (pts == 0) res.st = ST_EMPTY;
                else res.val = 32'(envelope_at(r.pos));
            end
            default: ;
        endcase
        if (res.st == ST_FULL) n_full++;
        if (res.st == ST_RANGE) n_range++;
        if (res.st == ST_EMPTY) n_empty++;
        res.cnt = 7'(pts);
        return res;
    endfunction

    task automatic queue_req(input logic [2:0] c, input logic [31:0] p,
                             input logic [31:0] v, input logic [5:0] i);
        env_req_t r;
        r.cmd = c;
        r.pos = p;
        r.val = v;
        r.idx = i;
        pending_reqs.insert(pending_reqs.size(), r);
        case (c)
            CMD_ADD:    if (gen_count < NPTS) gen_count++;
            CMD_REMOVE: if (i < gen_count) gen_count--;
            CMD_CLEAR:  gen_count = 0;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_pos();
        if ($urandom_range(0, 99) < 35) return $urandom;
        return {16'($urandom_range(0, 40)), $urandom_range(0, 3) == 0 ? 16'h0 : 16'($urandom)};
    endfunction

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || start || busy || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= m;
        mode_q = m;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // driver: a request leaves when start is high and busy is low
    always @(posedge clk or negedge rst_n)
    begin
        env_req_t nxt;
        logic     free;
        if (!rst_n)
        begin
            start       <= 1'b0;
            cmd         <= '0;
            position    <= '0;
            point_value <= '0;
            point_index <= '0;
        end
        else
        begin
            free = !start;
            if (start && !busy)
            begin
                expected_results.insert(expected_results.size(), apply_request(
                    '{cmd: cmd, pos: position, val: point_value, idx: point_index}));
                accepted++;
                free = 1'b1;
            end
            if (free)
            begin
                if (pending_reqs.size() != 0 &&
                    ((accepted > 500 && accepted < 800) || $urandom_range(0, 99) >= 21))
                begin
                    nxt = pending_reqs.pop_front();
                    start       <= 1'b1;
                    cmd         <= nxt.cmd;
                    position    <= nxt.pos;
                    point_value <= nxt.val;
                    point_index <= nxt.idx;
                end
                else start <= 1'b0;
            end
        end
    end

    // monitor: done marks a result for exactly one cycle
    always @(posedge clk)
    begin
        env_res_t e;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0) report("result with no request outstanding");
            else
            begin
                e = expected_results.pop_front();
                if (result_value !== e.val)
                    report($sformatf("value got %h exp %h", result_value, e.val));
                if (status !== e.st)
                    report($sformatf("status got %0d exp %0d", status, e.st));
                if (stored_count !== e.cnt)
                    report($sformatf("count got %0d exp %0d", stored_count, e.cnt));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        logic [1:0] modes[6];
        int r;
        int cnt;
        modes = '{MODE_STEP, MODE_COSINE, 2'd3, MODE_LINEAR, MODE_COSINE, MODE_LINEAR};
        errors = 0; accepted = 0; n_eval = 0; n_full = 0; n_range = 0; n_empty = 0;
        cycles = 0; pts = 0; mode_q = MODE_LINEAR; gen_count = 0;
        cfg_write = 1'b0;
        cfg_data  = '0;
        fill_weights();
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, ranges, equal positions, clamps, extremes
        queue_req(CMD_EVAL, 32'h1234, 0, 0);
        queue_req(CMD_REMOVE, 0, 0, 0);
        queue_req(CMD_SET, 0, 32'h1, 6'd63);
        queue_req(CMD_ADD, 32'h0001_0000, 32'h7FFF_FFFF, 0);
        queue_req(CMD_EVAL, 32'h0, 0, 0);
        queue_req(CMD_ADD, 32'hFFFF_FFFF, 32'h8000_0000, 0);
        queue_req(CMD_ADD, 32'h0001_0000, 32'h0000_0000, 0);
        queue_req(CMD_ADD, 32'h0, 32'hFFFF_FFFF, 0);
        queue_req(CMD_EVAL, 32'h0000_0000, 0, 0);
        queue_req(CMD_EVAL, 32'h0001_0000, 0, 0);
        queue_req(CMD_EVAL, 32'h8000_0000, 0, 0);
        queue_req(CMD_EVAL, 32'hFFFF_FFFF, 0, 0);
        queue_req(CMD_EVAL, 32'hFFFF_FFFE, 0, 0);
        queue_req(CMD_SET, 0, 32'h8000_0000, 6'd3);
        queue_req(CMD_EVAL, 32'h7FFF_0000, 0, 0);
        queue_req(CMD_REMOVE, 0, 0, 6'd4);
        queue_req(CMD_REMOVE, 0, 0, 6'd0);
        queue_req(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        queue_req(3'd7, 0, 0, 0);
        queue_req(CMD_CLEAR, 0, 0, 0);
        queue_req(CMD_ADD, 32'h0005_0000, 32'h0000_1000, 0);
        queue_req(CMD_EVAL, 32'h0009_0000, 0, 0);
        queue_req(CMD_REMOVE, 0, 0, 6'd0);
        queue_req(CMD_EVAL, 32'h0, 0, 0);
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_mode(modes[ph]);
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                r = $urandom_range(0, 99);
                cnt = gen_count;
                // phase two drives the table full and past it
                if ((ph == 1 && n < 120) ? r < 75 : (cnt < 4 ? r < 60 : r < 25))
                    queue_req(CMD_ADD, pick_pos(), $urandom, 6'($urandom));
                else if (r < 70)
                    queue_req(CMD_EVAL, pick_pos(), $urandom, 6'($urandom));
                else if (r < 80)
                    queue_req(CMD_SET, $urandom, $urandom, (cnt > 0 && r < 78) ?
                              6'($urandom_range(0, cnt - 1)) : 6'($urandom));
                else if (r < 92)
                    queue_req(CMD_REMOVE, $urandom, $urandom, (cnt > 0 && r < 89) ?
                              6'($urandom_range(0, cnt - 1)) : 6'($urandom));
                else if (r < 95)
                    queue_req(CMD_CLEAR, $urandom, $urandom, 6'($urandom));
                else
                    queue_req(3'($urandom_range(5, 7)), $urandom, $urandom, 6'($urandom));
            end
            wait_idle();
        end

        repeat (40) @(posedge clk);
        if (expected_results.size() != 0)
            report($sformatf("%0d results never arrived", expected_results.size()));
        $display("%0d requests over modes step, linear, cosine and 3; %0d evaluations",
                 accepted, n_eval);
        $display("full-table adds %0d, bad indices %0d, empty evaluations %0d",
                 n_full, n_range, n_empty);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
